>>> hdl/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg: shared types and constants of the clock frame replacement unit
// Field widths, action and status codes, item structs and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package cfr_pkg;

  localparam int FRAME_BITS  = 6;
  localparam int FRAME_COUNT = 1 << FRAME_BITS;
  localparam int PAGE_BITS   = 20;
  localparam int OWNER_BITS  = 8;
  localparam int RAM_WIDTH   = PAGE_BITS + OWNER_BITS;

  // free-frame scan looks at one group of frames a cycle
  localparam int GROUP_SIZE  = 8;
  localparam int GROUP_BITS  = $clog2(GROUP_SIZE);
  localparam int GSEL_BITS   = FRAME_BITS - GROUP_BITS;
  localparam int COUNT_BITS  = FRAME_BITS + 1;
  localparam int VISIT_BITS  = FRAME_BITS + 2;

  localparam logic [2:0] ACT_ALLOC  = 3'd0;
  localparam logic [2:0] ACT_FREE   = 3'd1;
  localparam logic [2:0] ACT_PIN    = 3'd2;
  localparam logic [2:0] ACT_UNPIN  = 3'd3;
  localparam logic [2:0] ACT_ACCESS = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_VICTIM = 2'd1;
  localparam logic [1:0] ST_UNTRACKED = 2'd2;

  typedef struct packed {
    logic [2:0]            action;
    logic [FRAME_BITS-1:0] frame_index;
    logic [PAGE_BITS-1:0]  virtual_page;
    logic [OWNER_BITS-1:0] owner_id;
    logic                  release_frame;
    logic                  is_write;
  } cfr_req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [FRAME_BITS-1:0] granted_frame;
    logic                  evicted;
    logic [PAGE_BITS-1:0]  evicted_page;
    logic [OWNER_BITS-1:0] evicted_owner;
    logic                  evicted_dirty;
  } cfr_rsp_t;

  typedef struct packed {
    logic capture;
    logic scan_step;
    logic prep;
    logic sweep_step;
    logic set_novictim;
    logic finish;
  } cfr_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic free_hit;
    logic scan_last;
    logic n_zero;
    logic exhausted;
    logic hit;
  } cfr_sts_t;

endpackage

>>> hdl/cfr_ram.sv
// ----------------------------------------------------------------------------
// cfr_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/cfr_datapath.sv
// ----------------------------------------------------------------------------
// cfr_datapath: frame flags, clock hand, page/owner store and result register
// Carries out the commands of the controller and reports scan and sweep
// status back to it.
// ----------------------------------------------------------------------------
module cfr_datapath (
  input  logic              clk,
  input  logic              rst,
  input  cfr_pkg::cfr_req_t req,
  input  cfr_pkg::cfr_cmd_t cmd,
  output cfr_pkg::cfr_sts_t sts,
  output cfr_pkg::cfr_rsp_t rsp
);
  import cfr_pkg::*;

  cfr_req_t               item;
  logic [FRAME_COUNT-1:0] pool;
  logic [FRAME_COUNT-1:0] trk;
  logic [FRAME_COUNT-1:0] pin;
  logic [FRAME_COUNT-1:0] refb;
  logic [FRAME_COUNT-1:0] dirt;
  logic [GSEL_BITS-1:0]   grp;
  logic [COUNT_BITS-1:0]  ntrk;
  logic [VISIT_BITS-1:0]  steps;
  logic [VISIT_BITS-1:0]  visits;
  logic [FRAME_BITS-1:0]  cand;
  logic [FRAME_BITS-1:0]  hand;
  logic                   hand_valid;
  logic [FRAME_BITS-1:0]  grant;
  logic                   evict;
  logic                   no_victim;

  logic [FRAME_BITS-1:0]  base;
  logic [GROUP_SIZE-1:0]  free_vec;
  logic [GROUP_SIZE-1:0]  trk_vec;
  logic [GROUP_BITS-1:0]  low_idx;
  logic [GROUP_BITS:0]    trk_cnt;
  logic                   hit;
  logic                   ok_target;
  logic                   alloc_ok;
  logic [RAM_WIDTH-1:0]   rd_data;
  cfr_rsp_t               res;

  assign base     = {grp, GROUP_BITS'(0)};
  assign free_vec = ~pool[base +: GROUP_SIZE];
  assign trk_vec  = trk[base +: GROUP_SIZE];

  always_comb begin
    low_idx = '0;
    for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        low_idx = GROUP_BITS'(i);
      end
    end
  end

  always_comb begin
    trk_cnt = '0;
    for (int i = 0; i < GROUP_SIZE; i++) begin
      trk_cnt = trk_cnt + (GROUP_BITS + 1)'(trk_vec[i]);
    end
  end

  assign hit       = trk[cand] & ~refb[cand] & ~pin[cand];
  assign ok_target = trk[item.frame_index];
  assign alloc_ok  = (item.action == ACT_ALLOC) && !no_victim;

  assign sts.is_alloc  = (item.action == ACT_ALLOC);
  assign sts.free_hit  = |free_vec;
  assign sts.scan_last = (grp == GSEL_BITS'(FRAME_COUNT / GROUP_SIZE - 1));
  assign sts.n_zero    = (ntrk == '0);
  assign sts.exhausted = (visits == steps);
  assign sts.hit       = hit;

  cfr_ram #(
    .WIDTH(RAM_WIDTH),
    .DEPTH(FRAME_COUNT)
  ) u_store (
    .clk    (clk),
    .wr_en  (cmd.finish & alloc_ok),
    .wr_addr(grant),
    .wr_data({item.virtual_page, item.owner_id}),
    .rd_en  (cmd.sweep_step & hit),
    .rd_addr(cand),
    .rd_data(rd_data)
  );

  always_comb begin
    res = '0;
    case (item.action)
      ACT_ALLOC: begin
        if (no_victim) begin
          res.status = ST_NO_VICTIM;
        end else begin
          res.granted_frame = grant;
          res.evicted       = evict;
          if (evict) begin
            res.evicted_page  = rd_data[RAM_WIDTH-1 -: PAGE_BITS];
            res.evicted_owner = rd_data[OWNER_BITS-1:0];
            res.evicted_dirty = dirt[grant];
          end
        end
      end
      ACT_FREE, ACT_PIN, ACT_UNPIN, ACT_ACCESS: begin
        if (!ok_target) begin
          res.status = ST_UNTRACKED;
        end
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
  end

  // flags and hand
  always_ff @(posedge clk) begin
    if (rst) begin
      pool       <= '0;
      trk        <= '0;
      pin        <= '0;
      refb       <= '0;
      dirt       <= '0;
      hand_valid <= 1'b0;
    end else begin
      if (cmd.sweep_step && trk[cand]) begin
        hand_valid <= 1'b1;
        refb[cand] <= 1'b0;
      end
      if (cmd.finish) begin
        case (item.action)
          ACT_ALLOC: begin
            if (!no_victim) begin
              pool[grant] <= 1'b1;
              trk[grant]  <= 1'b1;
              pin[grant]  <= 1'b1;
              refb[grant] <= 1'b0;
              dirt[grant] <= 1'b0;
            end
          end
          ACT_FREE: begin
            if (ok_target) begin
              trk[item.frame_index]  <= 1'b0;
              pin[item.frame_index]  <= 1'b0;
              refb[item.frame_index] <= 1'b0;
              dirt[item.frame_index] <= 1'b0;
              if (item.release_frame) begin
                pool[item.frame_index] <= 1'b0;
              end
            end
          end
          ACT_PIN: begin
            if (ok_target) begin
              pin[item.frame_index] <= 1'b1;
            end
          end
          ACT_UNPIN: begin
            if (ok_target) begin
              pin[item.frame_index] <= 1'b0;
            end
          end
          ACT_ACCESS: begin
            if (ok_target) begin
              refb[item.frame_index] <= 1'b1;
              if (item.is_write) begin
                dirt[item.frame_index] <= 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // working registers and result
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item      <= req;
      grp       <= '0;
      ntrk      <= '0;
      evict     <= 1'b0;
      no_victim <= 1'b0;
    end
    if (cmd.scan_step) begin
      grp  <= grp + 1'b1;
      ntrk <= ntrk + COUNT_BITS'(trk_cnt);
      if (|free_vec) begin
        grant <= {grp, low_idx};
      end
    end
    if (cmd.prep) begin
      steps  <= {ntrk, 1'b1};
      visits <= '0;
      cand   <= hand_valid ? hand + 1'b1 : '0;
    end
    if (cmd.sweep_step) begin
      cand <= cand + 1'b1;
      if (trk[cand]) begin
        visits <= visits + 1'b1;
        hand   <= cand;
      end
      if (hit) begin
        grant <= cand;
        evict <= 1'b1;
      end
    end
    if (cmd.set_novictim) begin
      no_victim <= 1'b1;
    end
    if (cmd.finish) begin
      rsp <= res;
    end
  end

endmodule

>>> hdl/cfr_ctrl.sv
// ----------------------------------------------------------------------------
// cfr_ctrl: sequencer of the clock frame replacement unit
// Steps alloc requests through free scan and clock sweep, every request
// through commit, and owns the request and response handshakes.
// ----------------------------------------------------------------------------
module cfr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  cfr_pkg::cfr_sts_t sts,
  output cfr_pkg::cfr_cmd_t cmd
);
  import cfr_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    SCAN,
    PREP,
    SWEEP,
    DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign req_ready = (state == IDLE);
  assign out_free  = !rsp_valid || rsp_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        cmd.capture = req_valid;
        if (req_valid) begin
          state_next = SCAN;
        end
      end
      SCAN: begin
        if (!sts.is_alloc) begin
          state_next = DONE;
        end else begin
          cmd.scan_step = 1'b1;
          if (sts.free_hit) begin
            state_next = DONE;
          end else if (sts.scan_last) begin
            state_next = PREP;
          end
        end
      end
      PREP: begin
        if (sts.n_zero) begin
          cmd.set_novictim = 1'b1;
          state_next       = DONE;
        end else begin
          cmd.prep   = 1'b1;
          state_next = SWEEP;
        end
      end
      SWEEP: begin
        if (sts.exhausted) begin
          cmd.set_novictim = 1'b1;
          state_next       = DONE;
        end else begin
          cmd.sweep_step = 1'b1;
          if (sts.hit) begin
            state_next = DONE;
          end
        end
      end
      DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hdl/clock_frame_replacement_unit.sv
// ----------------------------------------------------------------------------
// clock_frame_replacement_unit: physical frame table, second-chance eviction
// Request channel req_valid/req_ready/req carries one action per beat:
// alloc, free, pin, unpin or access. Response channel rsp_valid/rsp_ready/rsp
// returns one beat per request, in order.
// Requests are handled one at a time. Free, pin, unpin, access and unknown
// actions pass from the scan state straight to commit. Alloc scans for the
// lowest free frame a group of eight frames a cycle. With every frame in use
// the clock hand then visits one frame index per cycle until a victim is
// found or 2n+1 tracked frames have been visited, n being the tracked count.
// The next request is taken the cycle after a response is loaded, even
// while that response still waits for rsp_ready; a stalled receiver holds
// only the following response in its commit state.
// Reset clears every frame flag and the response valid; the clock hand
// starts its first sweep at frame 0. Page and owner storage is not cleared.
// ----------------------------------------------------------------------------
module clock_frame_replacement_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  cfr_pkg::cfr_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output cfr_pkg::cfr_rsp_t rsp
);
  import cfr_pkg::*;

  cfr_cmd_t cmd;
  cfr_sts_t sts;

  cfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cfr_datapath u_dp (
    .clk(clk),
    .rst(rst),
    .req(req),
    .cmd(cmd),
    .sts(sts),
    .rsp(rsp)
  );

endmodule
